FILE: design/mbca_pkg.sv
// package for the memory bank conflict arbiter: microcode word, jump conditions,
// the control program and the fixed constants of the request format
// no dependencies
`timescale 1ns / 1ps

package mbca_pkg;

	localparam int REQ_BITS     = 6;
	localparam int REQ_FIELDS   = 8;
	localparam int MASK_BITS    = 8;
	localparam int CYCLE_BITS   = 20;
	localparam int SUM_BITS     = 23;
	localparam int SERVED_BITS  = 4;
	localparam int PROCS_BITS   = 4;
	localparam int MODS_BITS    = 7;
	localparam int DIV_STEPS    = CYCLE_BITS / 2;
	localparam int DIV_CNT_BITS = 4;
	localparam int PC_BITS      = 3;

	localparam logic [CYCLE_BITS-1:0] CYCLE_LIMIT = CYCLE_BITS'(1000000);

	localparam int DEF_PROCS       = 8;
	localparam int DEF_MODULES     = 64;
	localparam int DEF_COUNT_WIDTH = 20;

	localparam logic [PROCS_BITS-1:0] RESET_PROCS = 4'd8;
	localparam logic [MODS_BITS-1:0]  RESET_MODS  = 7'd64;

	typedef enum logic {
		REG_ACTIVE_PROCS = 1'b0,
		REG_MODULE_COUNT = 1'b1
	} mbca_reg_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_NO_REQ,
		COND_MORE_ARB,
		COND_SUM_DONE,
		COND_ZERO_COUNT,
		COND_DIV_BUSY,
		COND_OUT_BUSY,
		COND_ALWAYS
	} mbca_cond_t;

	typedef logic [PC_BITS-1:0] mbca_pc_t;

	typedef struct packed {
		mbca_cond_t cond;
		mbca_pc_t   target;
		logic       take_req;
		logic       arb;
		logic       sum_init;
		logic       div_load;
		logic       div_step;
		logic       div_acc;
		logic       finish;
	} mbca_uword_t;

	localparam mbca_pc_t PC_WAIT   = 3'd0;
	localparam mbca_pc_t PC_ARB    = 3'd1;
	localparam mbca_pc_t PC_INIT   = 3'd2;
	localparam mbca_pc_t PC_CHECK  = 3'd3;
	localparam mbca_pc_t PC_LOAD   = 3'd4;
	localparam mbca_pc_t PC_DIV    = 3'd5;
	localparam mbca_pc_t PC_ACC    = 3'd6;
	localparam mbca_pc_t PC_FINISH = 3'd7;

	// control store: a false condition falls through to the next step,
	// the last step wraps back to the wait step
	function automatic mbca_uword_t ucode(input mbca_pc_t pc);
		mbca_uword_t w;
		w = '0;
		w.cond = COND_NEVER;
		case (pc)
			PC_WAIT: begin
				w.cond = COND_NO_REQ; w.target = PC_WAIT; w.take_req = 1'b1;
			end
			PC_ARB: begin
				w.cond = COND_MORE_ARB; w.target = PC_ARB; w.arb = 1'b1;
			end
			PC_INIT: begin
				w.cond = COND_NEVER; w.sum_init = 1'b1;
			end
			PC_CHECK: begin
				w.cond = COND_SUM_DONE; w.target = PC_FINISH;
			end
			PC_LOAD: begin
				w.cond = COND_ZERO_COUNT; w.target = PC_CHECK; w.div_load = 1'b1;
			end
			PC_DIV: begin
				w.cond = COND_DIV_BUSY; w.target = PC_DIV; w.div_step = 1'b1;
			end
			PC_ACC: begin
				w.cond = COND_ALWAYS; w.target = PC_CHECK; w.div_acc = 1'b1;
			end
			PC_FINISH: begin
				w.cond = COND_OUT_BUSY; w.target = PC_FINISH; w.finish = 1'b1;
			end
			default: begin
				w.cond = COND_NEVER;
			end
		endcase
		return w;
	endfunction

endpackage

FILE: design/memory_bank_conflict_arbiter_top.sv
// memory bank conflict arbiter, top level: microcoded sequencer, arbitration
// datapath and a shared two-bits-per-cycle divider for the access time sum
// depends on mbca_pkg
`timescale 1ns / 1ps

// One request is one bus cycle of up to eight processors asking for memory
// modules. It is taken only while the sequencer waits at its first step; the
// result sits in an output register, so the next request is taken while a
// result still waits. A request runs arbitration over the active processors
// in turn, then a pass over the processors in which each one with at least
// one access so far goes through the single shared divider at two quotient
// bits per cycle.
module memory_bank_conflict_arbiter_top #(
	parameter int PROCS       = mbca_pkg::DEF_PROCS,
	parameter int MODULES     = mbca_pkg::DEF_MODULES,
	parameter int COUNT_WIDTH = mbca_pkg::DEF_COUNT_WIDTH
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              cfg_we,
	input  logic                                              cfg_index,
	input  logic [mbca_pkg::MODS_BITS-1:0]                    cfg_data,
	input  logic                                              in_valid,
	output logic                                              in_ready,
	input  logic [mbca_pkg::REQ_BITS*mbca_pkg::REQ_FIELDS-1:0] requests,
	output logic                                              out_valid,
	input  logic                                              out_ready,
	output logic [mbca_pkg::MASK_BITS-1:0]                    grant_mask,
	output logic [mbca_pkg::MASK_BITS-1:0]                    denied_mask,
	output logic [mbca_pkg::MASK_BITS-1:0]                    invalid_mask,
	output logic [mbca_pkg::SUM_BITS-1:0]                     access_time_sum,
	output logic [mbca_pkg::SERVED_BITS-1:0]                  served_count
);

	localparam int PW = $clog2(PROCS);
	localparam int MW = $clog2(MODULES);
	localparam int CW = COUNT_WIDTH;
	localparam int RB = mbca_pkg::REQ_BITS;
	localparam int NB = mbca_pkg::CYCLE_BITS;

	// configuration
	logic [mbca_pkg::PROCS_BITS-1:0] active_procs_q;
	logic [mbca_pkg::MODS_BITS-1:0]  module_count_q;
	logic [mbca_pkg::PROCS_BITS-1:0] procs;
	logic [mbca_pkg::MODS_BITS-1:0]  mods;

	// sequencer
	mbca_pkg::mbca_pc_t    pc_q;
	mbca_pkg::mbca_uword_t uw;
	logic                  cond_true;
	logic                  out_free;

	// arbiter state
	logic [RB-1:0]   held_q [PROCS];
	logic [PROCS-1:0] was_denied_q;
	logic [CW-1:0]   count_q [PROCS];
	logic [NB-1:0]   cycle_q;
	logic            first_valid_q;
	logic [2:0]      first_index_q;

	// per request working registers
	logic [RB*mbca_pkg::REQ_FIELDS-1:0]  requests_q;
	logic [mbca_pkg::PROCS_BITS-1:0]     start_q;
	logic [mbca_pkg::PROCS_BITS-1:0]     i_q;
	logic [mbca_pkg::PROCS_BITS-1:0]     k_q;
	logic [MODULES-1:0]                  busy_q;
	logic [mbca_pkg::MASK_BITS-1:0]      grant_q, denied_q, invalid_q;
	logic                                any_denied_q;
	logic [2:0]                          new_first_q;
	logic [mbca_pkg::SUM_BITS-1:0]       sum_q;
	logic [mbca_pkg::SERVED_BITS-1:0]    served_q;

	// divider
	logic [NB-1:0]                     dvd_q;
	logic [CW-1:0]                     rem_q;
	logic [CW-1:0]                     dsr_q;
	logic [mbca_pkg::DIV_CNT_BITS-1:0] div_cnt_q;
	logic [CW:0]                       r1, r1s, r2, r2s;
	logic                              ge1, ge2;
	logic [CW-1:0]                     rem1;

	// arbitration combinational
	logic [mbca_pkg::PROCS_BITS-1:0] s_sum, p;
	logic [PW-1:0]                   cnt_idx;
	logic [CW-1:0]                   cnt_rd;
	logic [RB-1:0]                   req;
	logic                            req_invalid, req_busy;
	logic [mbca_pkg::PROCS_BITS-1:0] i_next;
	logic [2:0]                      start_calc;

	function automatic logic [2:0] start_mod(input logic [2:0] idx,
			input logic [mbca_pkg::PROCS_BITS-1:0] n);
		logic [mbca_pkg::PROCS_BITS-1:0] r;
		r = {1'b0, idx};
		for (int j = 0; j < 8; j++) begin
			if (r >= n)
				r = r - n;
		end
		return r[2:0];
	endfunction

	always_comb begin
		if (active_procs_q == '0)
			procs = mbca_pkg::PROCS_BITS'(1);
		else if (active_procs_q > mbca_pkg::PROCS_BITS'(PROCS))
			procs = mbca_pkg::PROCS_BITS'(PROCS);
		else
			procs = active_procs_q;
		if (module_count_q == '0)
			mods = mbca_pkg::MODS_BITS'(1);
		else if (module_count_q > mbca_pkg::MODS_BITS'(MODULES))
			mods = mbca_pkg::MODS_BITS'(MODULES);
		else
			mods = module_count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_procs_q <= mbca_pkg::RESET_PROCS;
			module_count_q <= mbca_pkg::RESET_MODS;
		end else if (cfg_we) begin
			case (mbca_pkg::mbca_reg_t'(cfg_index))
				mbca_pkg::REG_ACTIVE_PROCS: active_procs_q <= cfg_data[mbca_pkg::PROCS_BITS-1:0];
				mbca_pkg::REG_MODULE_COUNT: module_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- sequencer
	assign uw       = mbca_pkg::ucode(pc_q);
	assign out_free = !out_valid || out_ready;
	assign in_ready = uw.take_req;

	assign s_sum   = start_q + i_q;
	assign p       = (s_sum >= procs) ? s_sum - procs : s_sum;
	assign i_next  = i_q + mbca_pkg::PROCS_BITS'(1);
	assign cnt_idx = uw.arb ? p[PW-1:0] : k_q[PW-1:0];
	assign cnt_rd  = count_q[cnt_idx];

	always_comb begin
		case (uw.cond)
			mbca_pkg::COND_NEVER:      cond_true = 1'b0;
			mbca_pkg::COND_NO_REQ:     cond_true = !in_valid;
			mbca_pkg::COND_MORE_ARB:   cond_true = i_next < procs;
			mbca_pkg::COND_SUM_DONE:   cond_true = k_q >= procs;
			mbca_pkg::COND_ZERO_COUNT: cond_true = cnt_rd == '0;
			mbca_pkg::COND_DIV_BUSY:   cond_true = div_cnt_q > mbca_pkg::DIV_CNT_BITS'(1);
			mbca_pkg::COND_OUT_BUSY:   cond_true = !out_free;
			mbca_pkg::COND_ALWAYS:     cond_true = 1'b1;
			default:                   cond_true = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= mbca_pkg::PC_WAIT;
		else if (cond_true)
			pc_q <= uw.target;
		else
			pc_q <= pc_q + mbca_pkg::PC_BITS'(1);
	end

	// ---------------- arbitration
	assign req         = was_denied_q[p[PW-1:0]] ? held_q[p[PW-1:0]] : requests_q[RB*p +: RB];
	assign req_invalid = {1'b0, req} >= mods;
	assign req_busy    = busy_q[req[MW-1:0]];
	assign start_calc  = first_valid_q ? start_mod(first_index_q, procs) : 3'd0;

	always_ff @(posedge clk) begin
		if (uw.take_req && in_valid)
			requests_q <= requests;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < PROCS; j++) begin
				held_q[j]  <= '0;
				count_q[j] <= '0;
			end
			was_denied_q  <= '0;
			cycle_q       <= '0;
			first_valid_q <= 1'b0;
			first_index_q <= '0;
			start_q       <= '0;
			i_q           <= '0;
			busy_q        <= '0;
			grant_q       <= '0;
			denied_q      <= '0;
			invalid_q     <= '0;
			any_denied_q  <= 1'b0;
			new_first_q   <= '0;
		end else begin
			if (uw.take_req && in_valid) begin
				start_q      <= {1'b0, start_calc};
				i_q          <= '0;
				busy_q       <= '0;
				grant_q      <= '0;
				denied_q     <= '0;
				invalid_q    <= '0;
				any_denied_q <= 1'b0;
			end
			if (uw.arb) begin
				i_q                  <= i_next;
				held_q[p[PW-1:0]]    <= req;
				if (req_invalid || req_busy) begin
					was_denied_q[p[PW-1:0]] <= 1'b1;
					denied_q[p[2:0]]        <= 1'b1;
					invalid_q[p[2:0]]       <= req_invalid;
					if (!any_denied_q) begin
						any_denied_q <= 1'b1;
						new_first_q  <= p[2:0];
					end
				end else begin
					was_denied_q[p[PW-1:0]] <= 1'b0;
					grant_q[p[2:0]]         <= 1'b1;
					busy_q[req[MW-1:0]]     <= 1'b1;
					if (cnt_rd != '1)
						count_q[p[PW-1:0]] <= cnt_rd + CW'(1);
				end
			end
			if (uw.finish && out_free) begin
				first_valid_q <= any_denied_q;
				first_index_q <= any_denied_q ? new_first_q : 3'd0;
				if (cycle_q < mbca_pkg::CYCLE_LIMIT - NB'(1))
					cycle_q <= cycle_q + NB'(1);
			end
		end
	end

	// ---------------- access time sum with shared divider
	always_comb begin
		r1   = {rem_q, dvd_q[NB-1]};
		ge1  = r1 >= {1'b0, dsr_q};
		r1s  = ge1 ? r1 - {1'b0, dsr_q} : r1;
		rem1 = r1s[CW-1:0];
		r2   = {rem1, dvd_q[NB-2]};
		ge2  = r2 >= {1'b0, dsr_q};
		r2s  = ge2 ? r2 - {1'b0, dsr_q} : r2;
	end

	always_ff @(posedge clk) begin
		if (uw.div_load) begin
			dvd_q <= cycle_q + NB'(1);
			rem_q <= '0;
			dsr_q <= cnt_rd;
		end else if (uw.div_step) begin
			dvd_q <= {dvd_q[NB-3:0], ge1, ge2};
			rem_q <= r2s[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			sum_q     <= '0;
			served_q  <= '0;
			div_cnt_q <= '0;
		end else begin
			if (uw.sum_init) begin
				k_q      <= '0;
				sum_q    <= '0;
				served_q <= '0;
			end
			if (uw.div_load) begin
				div_cnt_q <= mbca_pkg::DIV_CNT_BITS'(mbca_pkg::DIV_STEPS);
				// a processor without accesses is skipped
				if (cnt_rd == '0)
					k_q <= k_q + mbca_pkg::PROCS_BITS'(1);
			end
			if (uw.div_step)
				div_cnt_q <= div_cnt_q - mbca_pkg::DIV_CNT_BITS'(1);
			if (uw.div_acc) begin
				sum_q    <= sum_q + mbca_pkg::SUM_BITS'(dvd_q);
				served_q <= served_q + mbca_pkg::SERVED_BITS'(1);
				k_q      <= k_q + mbca_pkg::PROCS_BITS'(1);
			end
		end
	end

	// ---------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (uw.finish && out_free)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (uw.finish && out_free) begin
			grant_mask      <= grant_q;
			denied_mask     <= denied_q;
			invalid_mask    <= invalid_q;
			access_time_sum <= sum_q;
			served_count    <= served_q;
		end
	end

endmodule
